### hw/rtl/lfsr_range_permutation_core_assert.svh
// ----------------------------------------------------------------------------
// LFSR range permutation assertion macros
// Shared concurrent assertion forms for the range permutation checker.
// ----------------------------------------------------------------------------
`ifndef LFSR_RANGE_PERMUTATION_CORE_ASSERT_SVH
`define LFSR_RANGE_PERMUTATION_CORE_ASSERT_SVH

// same-cycle implication
`define LRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrp assertion failed");

// next-cycle implication
`define LRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrp assertion failed");

// next-cycle implication that also holds across reset
`define LRP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lrp assertion failed");

`endif

### hw/rtl/lrp_pkg.sv
// ----------------------------------------------------------------------------
// LFSR range permutation package
// Register indexes, tap table, degree and mask helpers, result struct.
// ----------------------------------------------------------------------------
package lrp_pkg;

   localparam int CountW = 31;
   localparam int ByteW  = 8;
   localparam int TapW   = 30;
   localparam int DegW   = 5;
   localparam int CsrIdxW = 2;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LOWER_BOUND = 2'd0,
      CSR_UPPER_BOUND = 2'd1,
      CSR_FILL_COUNT  = 2'd2
   } csr_index_type;

   // Galois tap words by degree; degree d has its top tap at bit d-1
   localparam logic [TapW-1:0] TAP_WORDS [0:(1<<DegW)-1] = '{
      30'h0000_0000, 30'h0000_0001, 30'h0000_0003, 30'h0000_0006,
      30'h0000_000C, 30'h0000_0014, 30'h0000_0030, 30'h0000_0060,
      30'h0000_00B8, 30'h0000_0110, 30'h0000_0240, 30'h0000_0500,
      30'h0000_0CA0, 30'h0000_1B00, 30'h0000_3500, 30'h0000_6000,
      30'h0000_B400, 30'h0001_2000, 30'h0003_9000, 30'h0007_2000,
      30'h0009_0000, 30'h0014_0000, 30'h0030_0000, 30'h0042_0000,
      30'h00D8_0000, 30'h0120_0000, 30'h0388_0000, 30'h0720_0000,
      30'h0900_0000, 30'h1400_0000, 30'h3280_0000, 30'h0000_0000
   };

   typedef struct packed {
      logic             emit;
      logic [ByteW-1:0] value;
      logic             last;
   } lrp_result_type;

   // ceil(log2(count)), 0 for a count of 0 or 1, up to 31
   function automatic logic [DegW-1:0] degree_for(logic [CountW-1:0] count);
      logic [DegW-1:0] deg;
      deg = '0;
      for (int i = 0; i < CountW; i++) begin
         if ({1'b0, count} > (32'd1 << i)) begin
            deg = DegW'(i + 1);
         end
      end
      return deg;
   endfunction

   // smallest all-ones word covering span
   function automatic logic [ByteW-1:0] range_mask(logic [ByteW-1:0] span);
      logic [ByteW-1:0] m;
      m = span;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      return m;
   endfunction

endpackage

### hw/rtl/lrp_step.sv
// ----------------------------------------------------------------------------
// LFSR range permutation step
// One tick: optional reload, bound test, emit, Galois shift.
// ----------------------------------------------------------------------------
module lrp_step
   import lrp_pkg::*;
#(
   parameter int LFSR_W = 30
) (
   input  logic              restart,
   input  logic [LFSR_W-1:0] reload_taps,
   input  logic [CountW-1:0] fill_count,
   input  logic [ByteW-1:0]  lower_bound,
   input  logic [ByteW-1:0]  upper_bound,
   input  logic [LFSR_W-1:0] taps_cur,
   input  logic [LFSR_W-1:0] shift_cur,
   input  logic              prior_cur,
   input  logic [CountW-1:0] remaining_cur,
   output logic [LFSR_W-1:0] taps_next,
   output logic [LFSR_W-1:0] shift_next,
   output logic              prior_next,
   output logic [CountW-1:0] remaining_next,
   output lrp_result_type    result
);

   logic [LFSR_W-1:0] taps_eff;
   logic [LFSR_W-1:0] shift_eff;
   logic              prior_eff;
   logic [CountW-1:0] remaining_eff;
   logic              active;
   logic [ByteW-1:0]  mask;
   logic [ByteW-1:0]  offset;
   logic [ByteW:0]    sum;
   logic [LFSR_W-1:0] shifted;

   always_comb begin
      // restart reloads before this tick's step
      taps_eff      = restart ? reload_taps : taps_cur;
      shift_eff     = restart ? reload_taps : shift_cur;
      prior_eff     = restart ? 1'b0 : prior_cur;
      remaining_eff = restart ? fill_count : remaining_cur;

      active = (remaining_eff != '0);
      mask   = range_mask(upper_bound - lower_bound);
      offset = ByteW'(shift_eff) & mask;
      sum    = {1'b0, lower_bound} + {1'b0, offset};

      result.emit  = active && (sum <= {1'b0, upper_bound});
      result.value = sum[ByteW-1:0];
      result.last  = (remaining_eff == CountW'(1));

      shifted = (shift_eff >> 1) ^ (prior_eff ? taps_eff : '0);

      taps_next      = taps_eff;
      shift_next     = active ? shifted : shift_eff;
      prior_next     = active ? shifted[0] : prior_eff;
      remaining_next = result.emit ? remaining_eff - CountW'(1) : remaining_eff;
   end

endmodule

### hw/rtl/lfsr_range_permutation_core.sv
// ----------------------------------------------------------------------------
// LFSR range permutation core
// Pseudo-random, non-repeating byte sequence inside a configured range.
// ----------------------------------------------------------------------------
// Each accepted item is one tick of a right-shifting Galois LFSR. An item with
// req_restart set first reloads the LFSR with the tap word for degree
// ceil(log2(fill_count)) (clamped to MAX_DEGREE) as both polynomial and seed,
// and loads fill_count as the number of values still to emit. On every tick
// while values remain, lower_bound plus the low LFSR bits (masked to cover the
// range) is emitted if it does not exceed upper_bound; otherwise the tick
// produces no item. rsp_last marks the final value of a run. The block takes
// one item per cycle: the whole step (mask, add, compare, shift) sits between
// the LFSR state registers and the result register, and a new item is taken
// whenever the result register is empty or is being drained in the same cycle.
// The degree lookup runs when fill_count is written, not in the item path.
// Configuration writes belong in idle time, between runs.
// ----------------------------------------------------------------------------
module lfsr_range_permutation_core
   import lrp_pkg::*;
#(
   parameter int MAX_DEGREE = 30
) (
   input  logic                clock,
   input  logic                reset,
   // item input
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_restart,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ByteW-1:0]    rsp_value,
   output logic                rsp_last,
   // register writes
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CountW-1:0]   csr_wdata
);

   // LFSR width: degree d keeps its state in bits d-1..0
   localparam int LFSR_W = MAX_DEGREE;
   localparam int ResetDegree = (8 > MAX_DEGREE) ? MAX_DEGREE : 8;

   // configuration
   logic [ByteW-1:0]  lower_bound_ff;
   logic [ByteW-1:0]  upper_bound_ff;
   logic [CountW-1:0] fill_count_ff;
   logic [LFSR_W-1:0] reload_taps_ff;

   // generator state
   logic [LFSR_W-1:0] taps_ff, taps_in;
   logic [LFSR_W-1:0] shift_ff, shift_in;
   logic              prior_ff, prior_in;
   logic [CountW-1:0] remaining_ff, remaining_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0]  rsp_value_ff;
   logic              rsp_last_ff;

   logic              req_take;
   logic              rsp_take;
   logic [DegW-1:0]   wr_degree_raw;
   logic [DegW-1:0]   wr_degree;
   lrp_result_type    step_result;

   // --- register writes ----------------------------------------------------
   // degree and tap word are resolved here so the item path only muxes them
   assign wr_degree_raw = degree_for(csr_wdata);
   assign wr_degree     = (wr_degree_raw > DegW'(MAX_DEGREE)) ? DegW'(MAX_DEGREE)
                                                              : wr_degree_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_bound_ff <= '0;
         upper_bound_ff <= '1;
         fill_count_ff  <= CountW'(256);
         reload_taps_ff <= LFSR_W'(TAP_WORDS[ResetDegree]);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOWER_BOUND: begin
               lower_bound_ff <= csr_wdata[ByteW-1:0];
            end
            CSR_UPPER_BOUND: begin
               upper_bound_ff <= csr_wdata[ByteW-1:0];
            end
            CSR_FILL_COUNT: begin
               fill_count_ff  <= csr_wdata;
               reload_taps_ff <= LFSR_W'(TAP_WORDS[wr_degree]);
            end
            default: begin
               // unmapped index: write ignored
            end
         endcase
      end
   end

   // --- handshake ----------------------------------------------------------
   // stall only while a finished result waits and the consumer holds it
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   // --- one tick -----------------------------------------------------------
   lrp_step #(
      .LFSR_W (LFSR_W)
   ) u_step (
      .restart        (req_restart),
      .reload_taps    (reload_taps_ff),
      .fill_count     (fill_count_ff),
      .lower_bound    (lower_bound_ff),
      .upper_bound    (upper_bound_ff),
      .taps_cur       (taps_ff),
      .shift_cur      (shift_ff),
      .prior_cur      (prior_ff),
      .remaining_cur  (remaining_ff),
      .taps_next      (taps_in),
      .shift_next     (shift_in),
      .prior_next     (prior_in),
      .remaining_next (remaining_in),
      .result         (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff      <= '0;
         shift_ff     <= '0;
         prior_ff     <= 1'b0;
         remaining_ff <= '0;
      end else if (req_take) begin
         taps_ff      <= taps_in;
         shift_ff     <= shift_in;
         prior_ff     <= prior_in;
         remaining_ff <= remaining_in;
      end
   end

   // --- result register ----------------------------------------------------
   // a tick that emits nothing simply leaves the register empty
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = step_result.emit;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && step_result.emit) begin
         rsp_value_ff <= step_result.value;
         rsp_last_ff  <= step_result.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

### hw/rtl/lrp_checker.sv
// ----------------------------------------------------------------------------
// LFSR range permutation checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "lfsr_range_permutation_core_assert.svh"

module lrp_checker
   import lrp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [ByteW-1:0] rsp_value,
   input logic             rsp_last
);

   // held result keeps its payload
   `LRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value) && $stable(rsp_last))

   // input stalls only behind a held result
   `LRP_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // a drained result with no new item leaves the output empty
   `LRP_ASSERT_NEXT(a_drain, clock, reset, rsp_valid && !rsp_stall && !(req_valid && !req_stall), !rsp_valid)

   // reset empties the output
   `LRP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind lfsr_range_permutation_core lrp_checker u_checker (.*);
